// ----- hw/rtl/rsd_pkg.sv -----
// Shared types and constants for the raw socket demultiplexer table.
// Used by rsd_cell and raw_socket_demux_table; no dependencies.
`default_nettype none

package rsd_pkg;

	localparam int NUM_SOCKETS_DEF = 8;
	localparam int PROTO_W         = 8;
	localparam int ADDR_W          = 32;
	localparam int CNT_W           = 7;
	localparam int SLOT_W          = 3;
	localparam int REQ_W           = 3;
	localparam int STAT_W          = 3;

	// Largest queue depth honored, whatever the limit register holds
	localparam logic [CNT_W-1:0] QUEUE_MAX   = 7'd64;
	localparam logic [CNT_W-1:0] LIMIT_RESET = 7'd16;

	typedef enum logic [REQ_W-1:0] {
		REQ_CREATE  = 3'd0,
		REQ_BIND    = 3'd1,
		REQ_CONNECT = 3'd2,
		REQ_CLOSE   = 3'd3,
		REQ_ARRIVE  = 3'd4,
		REQ_RECV    = 3'd5,
		REQ_SEND    = 3'd6
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_NO_SLOT  = 3'd1,
		ST_UNREACH  = 3'd2,
		ST_DROPPED  = 3'd3,
		ST_EMPTY    = 3'd4,
		ST_MISMATCH = 3'd5,
		ST_BAD_SLOT = 3'd6
	} status_t;

	// Operation applied to the selected cell
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD,
		OP_SET_LOCAL,
		OP_SET_REMOTE,
		OP_INC,
		OP_DEC,
		OP_CLOSE
	} cell_op_t;

	// Socket contents held by one cell (slot id travels separately)
	typedef struct packed {
		logic               vld;
		logic [PROTO_W-1:0] proto;
		logic [ADDR_W-1:0]  laddr;
		logic [ADDR_W-1:0]  raddr;
		logic [CNT_W-1:0]   cnt;
	} cell_data_t;

	// Request fields broadcast to every cell at accept time
	typedef struct packed {
		logic               cap;
		logic [PROTO_W-1:0] proto;
		logic [ADDR_W-1:0]  src;
		logic [ADDR_W-1:0]  dst;
		logic [CNT_W-1:0]   lim;
	} cell_probe_t;

	// Update broadcast to every cell in the execute cycle
	typedef struct packed {
		cell_op_t           op;
		logic [PROTO_W-1:0] proto;
		logic [ADDR_W-1:0]  set_ip;
	} cell_cmd_t;

	// Per-cell compare results registered at accept
	typedef struct packed {
		logic pkt_hit;
		logic id_hit;
		logic below_lim;
		logic cnt_zero;
		logic send_bad;
	} cell_flags_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rsd_cell.sv -----
// One position of the creation-ordered socket chain.
// Holds a socket, compares it against a request, passes priority and shift chains.
// Depends on rsd_pkg.
`default_nettype none

module rsd_cell #(
	parameter int IdW = 3
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  rsd_pkg::cell_probe_t probe,
	input  wire  [IdW-1:0]       probe_id,
	input  wire                  probe_id_ok,
	input  rsd_pkg::cell_cmd_t   cmd,
	input  wire                  sel,
	input  wire  [IdW-1:0]       load_id,
	input  rsd_pkg::cell_data_t  nxt,
	input  wire  [IdW-1:0]       nxt_id,
	input  wire                  found_in,
	output logic                 found_out,
	input  wire                  full_in,
	output logic                 full_out,
	input  wire                  rm_in,
	output logic                 rm_out,
	output logic                 pkt_first,
	output logic                 free_first,
	output rsd_pkg::cell_data_t  cur,
	output logic [IdW-1:0]       cur_id,
	output rsd_pkg::cell_flags_t flags
);

	rsd_pkg::cell_data_t  data_q;
	logic [IdW-1:0]       id_q;
	rsd_pkg::cell_flags_t flags_q;
	rsd_pkg::cell_flags_t flags_d;
	logic                 rm_here;

	assign cur    = data_q;
	assign cur_id = id_q;
	assign flags  = flags_q;

	// Compare against the incoming request; wildcard fields are zero
	always_comb begin
		flags_d.pkt_hit   = data_q.vld
			&& (data_q.proto == '0 || data_q.proto == probe.proto)
			&& (data_q.raddr == '0 || data_q.raddr == probe.src)
			&& (data_q.laddr == '0 || data_q.laddr == probe.dst);
		flags_d.id_hit    = data_q.vld && probe_id_ok && (id_q == probe_id);
		flags_d.below_lim = data_q.cnt < probe.lim;
		flags_d.cnt_zero  = data_q.cnt == '0;
		flags_d.send_bad  = data_q.raddr != '0 && data_q.raddr != probe.dst;
	end

	// First match in creation order, first empty position, removal shift
	assign found_out  = found_in | flags_q.pkt_hit;
	assign pkt_first  = flags_q.pkt_hit & ~found_in;
	assign full_out   = full_in & data_q.vld;
	assign free_first = ~data_q.vld & full_in;
	assign rm_here    = sel && (cmd.op == rsd_pkg::OP_CLOSE);
	assign rm_out     = rm_in | rm_here;

	// Socket: shift from the neighbor on removal, else apply the command;
	// compare flags load at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q  <= '0;
			id_q    <= '0;
			flags_q <= '0;
		end else begin
			if (probe.cap) begin
				flags_q <= flags_d;
			end
			if (rm_out) begin
				data_q <= nxt;
				id_q   <= nxt_id;
			end else if (sel) begin
				case (cmd.op)
					rsd_pkg::OP_LOAD: begin
						data_q.vld   <= 1'b1;
						data_q.proto <= cmd.proto;
						data_q.laddr <= '0;
						data_q.raddr <= '0;
						data_q.cnt   <= '0;
						id_q         <= load_id;
					end
					rsd_pkg::OP_SET_LOCAL: begin
						data_q.laddr <= cmd.set_ip;
					end
					rsd_pkg::OP_SET_REMOTE: begin
						data_q.raddr <= cmd.set_ip;
					end
					rsd_pkg::OP_INC: begin
						data_q.cnt <= data_q.cnt + 7'd1;
					end
					rsd_pkg::OP_DEC: begin
						data_q.cnt <= data_q.cnt - 7'd1;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/raw_socket_demux_table.sv -----
// Raw socket table with first-match packet demultiplexing over a cell chain.
// Accept sets busy and busy sets done, so the result strobe follows the busy cycle.
// A new request is refused while busy; cells compare at accept, then the
// first-match chain across all cells selects and updates in the busy cycle.
// Results cannot be stalled. Reset empties the table and sets queue_limit to 16.
// Depends on rsd_pkg and rsd_cell.
`default_nettype none

module raw_socket_demux_table #(
	parameter int NUM_SOCKETS = rsd_pkg::NUM_SOCKETS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	// request channel
	input  wire                         start,
	output logic                        busy,
	input  wire  [rsd_pkg::REQ_W-1:0]   req_type,
	input  wire  [rsd_pkg::SLOT_W-1:0]  slot,
	input  wire  [rsd_pkg::PROTO_W-1:0] proto,
	input  wire  [rsd_pkg::ADDR_W-1:0]  src_ip,
	input  wire  [rsd_pkg::ADDR_W-1:0]  dst_ip,
	input  wire  [rsd_pkg::ADDR_W-1:0]  set_ip,
	// configuration channel (queue_limit)
	input  wire                         cfg_valid,
	output logic                        cfg_ready,
	input  wire  [rsd_pkg::CNT_W-1:0]   cfg_data,
	// result channel
	output logic                        done,
	output logic [rsd_pkg::STAT_W-1:0]  status,
	output logic [rsd_pkg::SLOT_W-1:0]  slot_out,
	output logic [rsd_pkg::CNT_W-1:0]   queued_count
);

	localparam int IdW  = (NUM_SOCKETS > 1) ? $clog2(NUM_SOCKETS) : 1;
	localparam int SelW = (IdW > rsd_pkg::SLOT_W) ? IdW : rsd_pkg::SLOT_W;

	// control registers
	logic                        busy_q;
	logic                        done_q;
	logic [rsd_pkg::CNT_W-1:0]   limit_q;
	logic [NUM_SOCKETS-1:0]      in_use_q;
	rsd_pkg::status_t            status_q;
	logic [rsd_pkg::SLOT_W-1:0]  slot_q;
	logic [rsd_pkg::CNT_W-1:0]   count_q;

	// request captured at accept
	rsd_pkg::req_t               req_s1;
	logic [rsd_pkg::SLOT_W-1:0]  slot_s1;
	logic [IdW-1:0]              slot_id_s1;
	logic [rsd_pkg::PROTO_W-1:0] proto_s1;
	logic [rsd_pkg::ADDR_W-1:0]  set_ip_s1;

	logic                        accept;
	logic [SelW-1:0]             slot_wide;
	logic [IdW-1:0]              slot_id;
	logic                        slot_ok;
	rsd_pkg::cell_probe_t        probe;
	rsd_pkg::cell_cmd_t          cmd;

	// chain wiring
	rsd_pkg::cell_data_t         cur   [NUM_SOCKETS];
	logic [IdW-1:0]              cur_id[NUM_SOCKETS];
	rsd_pkg::cell_flags_t        flg   [NUM_SOCKETS];
	logic [NUM_SOCKETS:0]        found_c;
	logic [NUM_SOCKETS:0]        full_c;
	logic [NUM_SOCKETS:0]        rm_c;
	logic [NUM_SOCKETS-1:0]      pkt_first;
	logic [NUM_SOCKETS-1:0]      free_first;
	logic [NUM_SOCKETS-1:0]      id_hit;
	logic [NUM_SOCKETS-1:0]      sel;

	// execute-cycle decode
	logic [NUM_SOCKETS-1:0]      free_oh;
	logic [IdW-1:0]              new_id;
	logic                        table_full;
	logic [NUM_SOCKETS-1:0]      look;
	logic [rsd_pkg::CNT_W-1:0]   look_cnt;
	logic [IdW-1:0]              look_id;
	logic                        look_below;
	logic                        look_zero;
	logic                        look_bad;
	rsd_pkg::status_t            status_d;
	logic [rsd_pkg::SLOT_W-1:0]  slot_d;
	logic [rsd_pkg::CNT_W-1:0]   count_d;
	logic [NUM_SOCKETS-1:0]      in_use_d;
	rsd_pkg::cell_op_t           op_d;

	assign accept    = start & ~busy_q;
	assign busy      = busy_q;
	assign cfg_ready = ~busy_q;
	assign done      = done_q;
	assign status    = status_q;
	assign slot_out  = slot_q;
	assign queued_count = count_q;

	// slot range check and index at the table's id width
	assign slot_wide = SelW'(slot);
	assign slot_id   = slot_wide[IdW-1:0];
	assign slot_ok   = (SelW + 1)'(slot) < (SelW + 1)'(NUM_SOCKETS);

	// request fields to the cells; limit saturates at the largest queue
	always_comb begin
		probe.cap   = accept;
		probe.proto = proto;
		probe.src   = src_ip;
		probe.dst   = dst_ip;
		probe.lim   = (limit_q > rsd_pkg::QUEUE_MAX) ? rsd_pkg::QUEUE_MAX : limit_q;
	end

	assign found_c[0] = 1'b0;
	assign full_c[0]  = 1'b1;
	assign rm_c[0]    = 1'b0;

	// the chain, in creation order
	for (genvar i = 0; i < NUM_SOCKETS; i++) begin : g_cell
		rsd_pkg::cell_data_t nxt;
		logic [IdW-1:0]      nxt_id;

		if (i == NUM_SOCKETS - 1) begin : g_tail
			assign nxt    = '0;
			assign nxt_id = '0;
		end else begin : g_body
			assign nxt    = cur[i+1];
			assign nxt_id = cur_id[i+1];
		end

		rsd_cell #(
			.IdW(IdW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.probe      (probe),
			.probe_id   (slot_id),
			.probe_id_ok(slot_ok),
			.cmd        (cmd),
			.sel        (sel[i]),
			.load_id    (new_id),
			.nxt        (nxt),
			.nxt_id     (nxt_id),
			.found_in   (found_c[i]),
			.found_out  (found_c[i+1]),
			.full_in    (full_c[i]),
			.full_out   (full_c[i+1]),
			.rm_in      (rm_c[i]),
			.rm_out     (rm_c[i+1]),
			.pkt_first  (pkt_first[i]),
			.free_first (free_first[i]),
			.cur        (cur[i]),
			.cur_id     (cur_id[i]),
			.flags      (flg[i])
		);

		assign id_hit[i] = flg[i].id_hit;
	end

	// lowest free slot id: isolate the lowest clear bit, then encode
	assign free_oh    = ~in_use_q & (in_use_q + NUM_SOCKETS'(1));
	assign table_full = &in_use_q;

	always_comb begin
		new_id = '0;
		for (int i = 0; i < NUM_SOCKETS; i++) begin
			if (free_oh[i]) begin
				new_id = new_id | IdW'(i);
			end
		end
	end

	// read out the single cell picked by the request
	assign look = (req_s1 == rsd_pkg::REQ_ARRIVE) ? pkt_first : id_hit;

	always_comb begin
		look_cnt   = '0;
		look_id    = '0;
		look_below = 1'b0;
		look_zero  = 1'b0;
		look_bad   = 1'b0;
		for (int i = 0; i < NUM_SOCKETS; i++) begin
			if (look[i]) begin
				look_cnt   = look_cnt | cur[i].cnt;
				look_id    = look_id | cur_id[i];
				look_below = look_below | flg[i].below_lim;
				look_zero  = look_zero | flg[i].cnt_zero;
				look_bad   = look_bad | flg[i].send_bad;
			end
		end
	end

	// request decode and result
	always_comb begin
		status_d = rsd_pkg::ST_OK;
		slot_d   = slot_s1;
		count_d  = look_cnt;
		in_use_d = in_use_q;
		op_d     = rsd_pkg::OP_HOLD;
		sel      = look;
		case (req_s1)
			rsd_pkg::REQ_CREATE: begin
				sel = free_first;
				if (table_full) begin
					status_d = rsd_pkg::ST_NO_SLOT;
					slot_d   = '0;
					count_d  = '0;
				end else begin
					op_d     = rsd_pkg::OP_LOAD;
					slot_d   = rsd_pkg::SLOT_W'(new_id);
					count_d  = '0;
					in_use_d = in_use_q | free_oh;
				end
			end
			rsd_pkg::REQ_ARRIVE: begin
				if (!found_c[NUM_SOCKETS]) begin
					status_d = rsd_pkg::ST_UNREACH;
					slot_d   = '0;
					count_d  = '0;
				end else if (look_below) begin
					op_d    = rsd_pkg::OP_INC;
					slot_d  = rsd_pkg::SLOT_W'(look_id);
					count_d = look_cnt + 7'd1;
				end else begin
					status_d = rsd_pkg::ST_DROPPED;
					slot_d   = rsd_pkg::SLOT_W'(look_id);
				end
			end
			rsd_pkg::REQ_BIND, rsd_pkg::REQ_CONNECT, rsd_pkg::REQ_CLOSE,
			rsd_pkg::REQ_RECV, rsd_pkg::REQ_SEND: begin
				if (id_hit == '0) begin
					status_d = rsd_pkg::ST_BAD_SLOT;
					count_d  = '0;
				end else if (req_s1 == rsd_pkg::REQ_BIND) begin
					op_d = rsd_pkg::OP_SET_LOCAL;
				end else if (req_s1 == rsd_pkg::REQ_CONNECT) begin
					op_d = rsd_pkg::OP_SET_REMOTE;
				end else if (req_s1 == rsd_pkg::REQ_CLOSE) begin
					op_d     = rsd_pkg::OP_CLOSE;
					count_d  = '0;
					in_use_d = in_use_q & ~(NUM_SOCKETS'(1) << slot_id_s1);
				end else if (req_s1 == rsd_pkg::REQ_RECV) begin
					if (look_zero) begin
						status_d = rsd_pkg::ST_EMPTY;
						count_d  = '0;
					end else begin
						op_d    = rsd_pkg::OP_DEC;
						count_d = look_cnt - 7'd1;
					end
				end else if (look_bad) begin
					status_d = rsd_pkg::ST_MISMATCH;
				end
			end
			default: begin
				// unknown request code
				status_d = rsd_pkg::ST_BAD_SLOT;
				count_d  = '0;
			end
		endcase
	end

	// cell contents only change in the busy cycle
	always_comb begin
		cmd.op     = busy_q ? op_d : rsd_pkg::OP_HOLD;
		cmd.proto  = proto_s1;
		cmd.set_ip = set_ip_s1;
	end

	// control state and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			limit_q  <= rsd_pkg::LIMIT_RESET;
			in_use_q <= '0;
			status_q <= rsd_pkg::ST_OK;
			slot_q   <= '0;
			count_q  <= '0;
		end else begin
			busy_q <= accept;
			done_q <= busy_q;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (busy_q) begin
				in_use_q <= in_use_d;
				status_q <= status_d;
				slot_q   <= slot_d;
				count_q  <= count_d;
			end
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1     <= rsd_pkg::req_t'(req_type);
			slot_s1    <= slot;
			slot_id_s1 <= slot_id;
			proto_s1   <= proto;
			set_ip_s1  <= set_ip;
		end
	end

	// checks
	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> !busy_q)
		else $error("busy held longer than one cycle");

	a_done_follows_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("result strobe without a request in flight");

	a_first_match_unique: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot0(pkt_first))
		else $error("more than one first-match cell");

	a_slot_unique: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot0(id_hit))
		else $error("slot id held by more than one cell");

endmodule

`default_nettype wire
